// File: rtl/ppj_pkg.sv
// ----------------------------------------------------------------------------
// ppj_pkg
// Shared types and constants of the point to pixel projector.
// ----------------------------------------------------------------------------
package ppj_pkg;

   localparam int COORD_BITS  = 32;
   localparam int ACC_BITS    = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int RESET_WIDTH  = 1920;
   localparam int RESET_HEIGHT = 1080;

   // Configuration register indexes, one per 64-bit word.
   typedef enum logic [2:0] {
      REG_ROW0_AB      = 3'd0,
      REG_ROW0_CD      = 3'd1,
      REG_ROW1_AB      = 3'd2,
      REG_ROW1_CD      = 3'd3,
      REG_ROW2_AB      = 3'd4,
      REG_ROW2_CD      = 3'd5,
      REG_IMAGE_WIDTH  = 3'd6,
      REG_IMAGE_HEIGHT = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IN_IMAGE   = 2'd0,
      ST_ZERO_PLANE = 2'd1,
      ST_BEHIND     = 2'd2,
      ST_OUT_BOUNDS = 2'd3
   } status_type;

   // Twelve matrix coefficients, entry 4*row + column.
   typedef logic [11:0][COORD_BITS-1:0] coef_type;

   // One projected point handed from the front end to the back end.
   typedef struct packed {
      logic                       zero_plane;
      logic signed [ACC_BITS-1:0] u;
      logic signed [ACC_BITS-1:0] v;
      logic signed [ACC_BITS-1:0] w;
   } entry_type;

endpackage

// File: rtl/point_to_pixel_projector_unit.sv
// ----------------------------------------------------------------------------
// point_to_pixel_projector_unit
// Projects lidar points through a 3x4 matrix and divides down to pixels.
// ----------------------------------------------------------------------------
// A point passes the three front stages, the queue, the classify stage, one
// restoring-division stage per quotient bit and the output register. One point
// per cycle while neither the queue nor the result side stalls.
// Reset clears all valid bits and the queue; the matrix resets to zero and the
// image size to 1920 by 1080.
module point_to_pixel_projector_unit #(
   parameter int FRAC_BITS  = 16,
   parameter int PIXEL_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ppj_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [ppj_pkg::COORD_BITS-1:0] req_point_y,
   input  logic signed [ppj_pkg::COORD_BITS-1:0] req_point_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [PIXEL_BITS-1:0]                rsp_pixel_col,
   output logic [PIXEL_BITS-1:0]                rsp_pixel_row,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [5:0]                           csr_paddr,
   input  logic [63:0]                          csr_pwdata,
   output logic [63:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import ppj_pkg::*;

   // Configuration registers. Each 64-bit matrix word holds two Q16.16
   // coefficients, the lower column in the low half.
   coef_type              coef_ff;
   logic [PIXEL_BITS-1:0] width_ff, height_ff;
   reg_idx_type           csr_idx;
   logic                  csr_wr;

   // Front to back queue signals.
   logic      q_push, q_full, q_pop, q_empty;
   entry_type q_in, q_out;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         width_ff  <= PIXEL_BITS'(RESET_WIDTH);
         height_ff <= PIXEL_BITS'(RESET_HEIGHT);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ROW0_AB: coef_ff[1:0]   <= csr_pwdata;
            REG_ROW0_CD: coef_ff[3:2]   <= csr_pwdata;
            REG_ROW1_AB: coef_ff[5:4]   <= csr_pwdata;
            REG_ROW1_CD: coef_ff[7:6]   <= csr_pwdata;
            REG_ROW2_AB: coef_ff[9:8]   <= csr_pwdata;
            REG_ROW2_CD: coef_ff[11:10] <= csr_pwdata;
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[PIXEL_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[PIXEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ROW0_AB: csr_prdata = coef_ff[1:0];
         REG_ROW0_CD: csr_prdata = coef_ff[3:2];
         REG_ROW1_AB: csr_prdata = coef_ff[5:4];
         REG_ROW1_CD: csr_prdata = coef_ff[7:6];
         REG_ROW2_AB: csr_prdata = coef_ff[9:8];
         REG_ROW2_CD: csr_prdata = coef_ff[11:10];
         REG_IMAGE_WIDTH:  csr_prdata = 64'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 64'(height_ff);
         default: csr_prdata = '0;
      endcase
   end

   // The front end accepts transactions and forms u, v and w.
   ppj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .coef        (coef_ff),
      .queue_full  (q_full),
      .push        (q_push),
      .push_entry  (q_in)
   );

   // The queue lets the back end stall on the result side while the
   // front end keeps filling it.
   ppj_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (q_out)
   );

   // The back end classifies and divides, one quotient bit per stage.
   ppj_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (q_empty),
      .pop_entry     (q_out),
      .pop           (q_pop),
      .image_width   (width_ff),
      .image_height  (height_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_pixel_row (rsp_pixel_row)
   );

   // A rejected point never carries a pixel.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_IN_IMAGE |-> rsp_pixel_col == '0 && rsp_pixel_row == '0)
      else $error("rejected result carries a nonzero pixel");

   // An accepted pixel lies inside the configured image.
   a_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_IN_IMAGE |-> rsp_pixel_col < width_ff &&
      rsp_pixel_row < height_ff)
      else $error("in-image result lies outside the image");

   // The front end never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue overflow");

endmodule

// File: rtl/ppj_front.sv
// ----------------------------------------------------------------------------
// ppj_front
// Captures points, forms the twelve products and sums them into u, v, w.
// ----------------------------------------------------------------------------
module ppj_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ppj_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [ppj_pkg::COORD_BITS-1:0] req_point_y,
   input  logic signed [ppj_pkg::COORD_BITS-1:0] req_point_z,
   input  ppj_pkg::coef_type                    coef,
   input  logic                                 queue_full,
   output logic                                 push,
   output ppj_pkg::entry_type                   push_entry
);
   import ppj_pkg::*;

   logic                          en;
   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [COORD_BITS-1:0]  x_ff, y_ff, z_ff;
   logic                          zero_ff, zero2_ff;
   logic signed [ACC_BITS-1:0]    prod_ff [3][4];
   logic signed [ACC_BITS-1:0]    prod_in [3][4];
   logic signed [ACC_BITS-1:0]    sum_in  [3];
   entry_type                     entry_ff;

   // The whole front end holds while its last stage waits on a full queue.
   assign en        = !v3_ff || !queue_full;
   assign req_ready = en;
   assign push      = v3_ff && !queue_full;
   assign push_entry = entry_ff;

   always_comb begin
      logic signed [COORD_BITS-1:0] c0, c1, c2, c3;
      logic signed [ACC_BITS-1:0]   c3e;
      for (int r = 0; r < 3; r++) begin
         c0 = signed'(coef[4*r]);
         c1 = signed'(coef[4*r+1]);
         c2 = signed'(coef[4*r+2]);
         c3 = signed'(coef[4*r+3]);
         c3e = ACC_BITS'(c3);
         prod_in[r][0] = c0 * x_ff;
         prod_in[r][1] = c1 * y_ff;
         prod_in[r][2] = c2 * z_ff;
         // Constant column: coef * 2^FRAC_BITS / 4, exact.
         prod_in[r][3] = c3e <<< (FRAC_BITS - 2);
      end
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = (prod_ff[r][0] >>> 2) + (prod_ff[r][1] >>> 2)
                   + (prod_ff[r][2] >>> 2) + prod_ff[r][3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= req_valid;
         x_ff     <= req_point_x;
         y_ff     <= req_point_y;
         z_ff     <= req_point_z;
         zero_ff  <= (req_point_x == '0) && (req_point_y == '0);
         v2_ff    <= v1_ff;
         zero2_ff <= zero_ff;
         prod_ff  <= prod_in;
         v3_ff    <= v2_ff;
         entry_ff.zero_plane <= zero2_ff;
         entry_ff.u <= sum_in[0];
         entry_ff.v <= sum_in[1];
         entry_ff.w <= sum_in[2];
      end
   end

endmodule

// File: rtl/ppj_queue.sv
// ----------------------------------------------------------------------------
// ppj_queue
// Short FIFO that decouples the front end from the division back end.
// ----------------------------------------------------------------------------
module ppj_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ppj_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ppj_pkg::entry_type pop_entry
);
   import ppj_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]     count_ff;
   logic                  do_pop;

   assign full      = (count_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(do_pop);
      end
   end

endmodule

// File: rtl/ppj_back.sv
// ----------------------------------------------------------------------------
// ppj_back
// Classifies a point and divides u and v by w, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ppj_back #(
   parameter int PIXEL_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  ppj_pkg::entry_type    pop_entry,
   output logic                  pop,
   input  logic [PIXEL_BITS-1:0] image_width,
   input  logic [PIXEL_BITS-1:0] image_height,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [PIXEL_BITS-1:0] rsp_pixel_col,
   output logic [PIXEL_BITS-1:0] rsp_pixel_row
);
   import ppj_pkg::*;

   localparam int WIDE = ACC_BITS + PIXEL_BITS;

   typedef struct packed {
      logic                  valid;
      status_type            status;
      logic [ACC_BITS-1:0]   w;
      logic [ACC_BITS-1:0]   rem_u;
      logic [ACC_BITS-1:0]   rem_v;
      logic [PIXEL_BITS-1:0] q_u;
      logic [PIXEL_BITS-1:0] q_v;
   } stage_type;

   logic                  en;
   stage_type             stg_ff [PIXEL_BITS+1];
   stage_type             stg_in [PIXEL_BITS+1];
   logic                  out_valid_ff;
   status_type            out_status_ff;
   logic [PIXEL_BITS-1:0] out_col_ff, out_row_ff;

   assign en  = !out_valid_ff || rsp_ready;
   assign pop = en;

   always_comb begin
      logic signed [ACC_BITS-1:0] u, v, w, su, sv;
      logic [WIDE-1:0]            wtop, d;
      u = pop_entry.u;
      v = pop_entry.v;
      w = pop_entry.w;
      su = u + w;
      sv = v + w;
      wtop = WIDE'(w) << PIXEL_BITS;
      stg_in[0].valid  = !queue_empty;
      stg_in[0].status = ST_IN_IMAGE;
      stg_in[0].w      = w;
      stg_in[0].rem_u  = u;
      stg_in[0].rem_v  = v;
      stg_in[0].q_u    = '0;
      stg_in[0].q_v    = '0;
      // A negative numerator above -w truncates to a zero quotient.
      if (u < 0) begin
         stg_in[0].rem_u = '0;
      end
      if (v < 0) begin
         stg_in[0].rem_v = '0;
      end
      priority if (pop_entry.zero_plane) begin
         stg_in[0].status = ST_ZERO_PLANE;
      end else if (w <= 0) begin
         stg_in[0].status = ST_BEHIND;
      end else if ((u < 0 && su <= 0) || (v < 0 && sv <= 0)) begin
         stg_in[0].status = ST_OUT_BOUNDS;
      end else if ((u >= 0 && WIDE'(u) >= wtop) || (v >= 0 && WIDE'(v) >= wtop)) begin
         stg_in[0].status = ST_OUT_BOUNDS;
      end else begin
         stg_in[0].status = ST_IN_IMAGE;
      end

      for (int k = 0; k < PIXEL_BITS; k++) begin
         stg_in[k+1] = stg_ff[k];
         d = WIDE'(stg_ff[k].w) << (PIXEL_BITS - 1 - k);
         if (WIDE'(stg_ff[k].rem_u) >= d) begin
            stg_in[k+1].rem_u = stg_ff[k].rem_u - d[ACC_BITS-1:0];
            stg_in[k+1].q_u[PIXEL_BITS-1-k] = 1'b1;
         end
         if (WIDE'(stg_ff[k].rem_v) >= d) begin
            stg_in[k+1].rem_v = stg_ff[k].rem_v - d[ACC_BITS-1:0];
            stg_in[k+1].q_v[PIXEL_BITS-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= PIXEL_BITS; k++) begin
            stg_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         stg_ff       <= stg_in;
         out_valid_ff <= stg_ff[PIXEL_BITS].valid;
         if (stg_ff[PIXEL_BITS].status != ST_IN_IMAGE) begin
            out_status_ff <= stg_ff[PIXEL_BITS].status;
            out_col_ff    <= '0;
            out_row_ff    <= '0;
         end else if (stg_ff[PIXEL_BITS].q_u >= image_width ||
                      stg_ff[PIXEL_BITS].q_v >= image_height) begin
            out_status_ff <= ST_OUT_BOUNDS;
            out_col_ff    <= '0;
            out_row_ff    <= '0;
         end else begin
            out_status_ff <= ST_IN_IMAGE;
            out_col_ff    <= stg_ff[PIXEL_BITS].q_u;
            out_row_ff    <= stg_ff[PIXEL_BITS].q_v;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_pixel_col = out_col_ff;
   assign rsp_pixel_row = out_row_ff;

endmodule
